// ===== sv/arbitrary_axis_ocs_transform_core_defines.svh =====
// Assertion macros for the arbitrary axis OCS transform core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ARBITRARY_AXIS_OCS_TRANSFORM_CORE_DEFINES_SVH
`define ARBITRARY_AXIS_OCS_TRANSFORM_CORE_DEFINES_SVH

// ante implies cons in the same cycle
`define AAOCS_ASSERT_IMPLY(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// cond must never hold
`define AAOCS_ASSERT_NEVER(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
else $error(msg);

`endif

// ===== sv/aaocs_pkg.sv =====
// Shared widths, constants and types for the arbitrary axis OCS transform.
// No dependencies.
package aaocs_pkg;

	localparam int COORD_W    = 32;   // Q16.16 coordinates
	localparam int VEC_W      = 64;   // raw vector component into a normaliser
	localparam int UNIT_W     = 32;   // Q2.30 unit vector component
	localparam int MAG_W      = 31;   // scaled magnitude, top bit at 30
	localparam int ROOT_W     = 32;   // integer square root
	localparam int REM_W      = 35;   // square root partial remainder
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int UNIT_LAT   = 70;   // normaliser latency
	localparam int CORE_LAT   = 217;  // start to done

	localparam logic signed [COORD_W-1:0] ONE_Q16   = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam logic [UNIT_W-1:0]         EPS_Q30   = 32'h0100_0000;

	typedef struct packed {
		logic up;     // extrusion exactly (0,0,1)
		logic down;   // extrusion exactly (0,0,-1)
		logic zero;   // extrusion all zero
	} ext_case_t;

endpackage

// ===== sv/aaocs_unit.sv =====
// Pipelined vector normaliser: magnitude scaling, bit-serial square root
// stages, then restoring divide stages. Depends on aaocs_pkg.
module aaocs_unit import aaocs_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [2:0][VEC_W-1:0]         in_vec,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic [2:0][UNIT_W-1:0]        out_vec,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int CW = SIDE_W + 4;   // {zero, neg[2:0], side}

	function automatic logic [5:0] msb_pos(input logic [VEC_W-1:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < VEC_W; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	logic [UNIT_LAT-1:0] vld_s;
	logic [CW-1:0]       cr_s [UNIT_LAT];

	logic [2:0][VEC_W-1:0]   mag_s1, mag_s2;
	logic [5:0]              pos_s2;
	logic [2:0][MAG_W-1:0]   mag_s3, mag_s4;
	logic [2:0][2*MAG_W-1:0] sq_s4;
	logic [2:0][MAG_W-1:0]   sh_c;

	// square root stages, index 0 is the sum-of-squares register
	logic [REM_W-1:0]      rt_rem  [ROOT_STEPS+1];
	logic [ROOT_W-1:0]     rt_root [ROOT_STEPS+1];
	logic [VEC_W-1:0]      rt_n    [ROOT_STEPS+1];
	logic [2:0][MAG_W-1:0] rt_mag  [ROOT_STEPS+1];
	logic [REM_W-1:0]      rt_r2   [ROOT_STEPS];
	logic [REM_W-1:0]      rt_try  [ROOT_STEPS];
	logic                  rt_ge   [ROOT_STEPS];

	// divide stages, index 0 is the dividend set-up register
	logic [2:0][ROOT_W:0]    dv_rem [DIV_STEPS+1];
	logic [2:0][MAG_W-1:0]   dv_low [DIV_STEPS+1];
	logic [2:0][MAG_W-1:0]   dv_q   [DIV_STEPS+1];
	logic [ROOT_W-1:0]       dv_len [DIV_STEPS+1];
	logic [2:0][ROOT_W:0]    dv_r2  [DIV_STEPS];
	logic [2:0]              dv_ge  [DIV_STEPS];
	logic [2:0][2*MAG_W-1:0] dvd_c;

	logic [CW-1:0] cr_in;
	logic [CW-1:0] cr_fin;

	always_comb begin
		cr_in = {(in_vec == '0), in_vec[2][VEC_W-1], in_vec[1][VEC_W-1],
			in_vec[0][VEC_W-1], in_side};
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= 6'd30) sh_c[i] = MAG_W'(mag_s2[i] >> (pos_s2 - 6'd30));
			else                 sh_c[i] = MAG_W'(mag_s2[i] << (6'd30 - pos_s2));
			dvd_c[i] = {rt_mag[ROOT_STEPS][i], 30'd0}
				+ (2*MAG_W)'(rt_root[ROOT_STEPS] >> 1);
		end
		for (int k = 0; k < ROOT_STEPS; k++) begin
			rt_r2[k]  = {rt_rem[k][REM_W-3:0], rt_n[k][VEC_W-1:VEC_W-2]};
			rt_try[k] = {1'b0, rt_root[k], 2'b01};
			rt_ge[k]  = rt_r2[k] >= rt_try[k];
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int i = 0; i < 3; i++) begin
				dv_r2[j][i] = {dv_rem[j][i][ROOT_W-1:0], dv_low[j][i][MAG_W-1]};
				dv_ge[j][i] = dv_r2[j][i] >= {1'b0, dv_len[j]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[UNIT_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		cr_s[0] <= cr_in;
		for (int k = 1; k < UNIT_LAT; k++) cr_s[k] <= cr_s[k-1];
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= in_vec[i][VEC_W-1] ? (VEC_W'(0) - in_vec[i]) : in_vec[i];
			sq_s4[i]  <= (2*MAG_W)'(mag_s3[i]) * (2*MAG_W)'(mag_s3[i]);
		end
		mag_s2 <= mag_s1;
		pos_s2 <= msb_pos(mag_s1[0] | mag_s1[1] | mag_s1[2]);
		mag_s3 <= sh_c;
		mag_s4 <= mag_s3;

		rt_n[0]    <= VEC_W'(sq_s4[0]) + VEC_W'(sq_s4[1]) + VEC_W'(sq_s4[2]);
		rt_rem[0]  <= '0;
		rt_root[0] <= '0;
		rt_mag[0]  <= mag_s4;
		for (int k = 0; k < ROOT_STEPS; k++) begin
			rt_rem[k+1]  <= rt_ge[k] ? (rt_r2[k] - rt_try[k]) : rt_r2[k];
			rt_root[k+1] <= {rt_root[k][ROOT_W-2:0], rt_ge[k]};
			rt_n[k+1]    <= {rt_n[k][VEC_W-3:0], 2'b00};
			rt_mag[k+1]  <= rt_mag[k];
		end

		dv_len[0] <= rt_root[ROOT_STEPS];
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= {2'b00, dvd_c[i][2*MAG_W-1:MAG_W]};
			dv_low[0][i] <= dvd_c[i][MAG_W-1:0];
			dv_q[0][i]   <= '0;
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			dv_len[j+1] <= dv_len[j];
			for (int i = 0; i < 3; i++) begin
				dv_rem[j+1][i] <= dv_ge[j][i] ? (dv_r2[j][i] - {1'b0, dv_len[j]})
					: dv_r2[j][i];
				dv_low[j+1][i] <= {dv_low[j][i][MAG_W-2:0], 1'b0};
				dv_q[j+1][i]   <= {dv_q[j][i][MAG_W-2:0], dv_ge[j][i]};
			end
		end

		for (int i = 0; i < 3; i++) begin
			if (cr_fin[CW-1])
				out_vec[i] <= '0;
			else if (cr_fin[SIDE_W+i])
				out_vec[i] <= UNIT_W'(0) - {1'b0, dv_q[DIV_STEPS][i]};
			else
				out_vec[i] <= {1'b0, dv_q[DIV_STEPS][i]};
		end
	end

	assign cr_fin    = cr_s[UNIT_LAT-2];
	assign out_valid = vld_s[UNIT_LAT-1];
	assign out_side  = cr_s[UNIT_LAT-1][SIDE_W-1:0];

endmodule

// ===== sv/arbitrary_axis_ocs_transform_core.sv =====
// Arbitrary axis OCS transform: one point accepted every cycle, busy never
// raised (no stall path). Start to done runs through three normalisers
// (square root and divide stages, one bit per stage) and the cross/dot
// product logic.
// arst_n clears every valid bit; payload registers are not reset.
// Depends on aaocs_pkg, aaocs_unit and the core defines header.
`include "arbitrary_axis_ocs_transform_core_defines.svh"
module arbitrary_axis_ocs_transform_core import aaocs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic signed [COORD_W-1:0] extr_x,
	input  logic signed [COORD_W-1:0] extr_y,
	input  logic signed [COORD_W-1:0] extr_z,
	output logic                      done,
	output logic signed [COORD_W-1:0] ocs_x,
	output logic signed [COORD_W-1:0] ocs_y,
	output logic signed [COORD_W-1:0] ocs_z,
	output logic                      saturated,
	output logic                      zero_extrusion
);

	localparam int SIDE_A = 3 + 3*COORD_W;
	localparam int SIDE_B = SIDE_A + 3*UNIT_W;
	localparam int SIDE_C = SIDE_B + 3*UNIT_W;
	localparam int SUM_W  = 2*COORD_W + 2;

	// ---- s0: input beat register and special-case decode
	logic                      valid_s0;
	logic [2:0][COORD_W-1:0]   p_s0, e_s0;
	ext_case_t                 case_s0;
	logic [2:0][VEC_W-1:0]     ev_s0;

	always_ff @(posedge clk) begin
		if (start) begin
			p_s0 <= {point_z, point_y, point_x};
			e_s0 <= {extr_z, extr_y, extr_x};
		end
	end

	always_comb begin
		case_s0.up   = (e_s0[0] == '0) && (e_s0[1] == '0) && (e_s0[2] == ONE_Q16);
		case_s0.down = (e_s0[0] == '0) && (e_s0[1] == '0) && (e_s0[2] == -ONE_Q16);
		case_s0.zero = (e_s0 == '0);
		for (int i = 0; i < 3; i++) ev_s0[i] = VEC_W'($signed(e_s0[i]));
	end

	// ---- normaliser A: az from the extrusion
	logic                    va;
	logic [2:0][UNIT_W-1:0]  az_a;
	ext_case_t               case_a;
	logic [2:0][COORD_W-1:0] p_a;

	aaocs_unit #(.SIDE_W(SIDE_A)) u_norm_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s0),
		.in_vec   (ev_s0),
		.in_side  ({case_s0, p_s0}),
		.out_valid(va),
		.out_vec  (az_a),
		.out_side ({case_a, p_a})
	);

	// ---- s1: pick the x axis seed, Y x az or Z x az
	// Near-vertical extrusion (both |az.x| and |az.y| under 1/64) uses world Y.
	logic                        valid_s1;
	logic [2:0][VEC_W-1:0]       tx_s1;
	logic [SIDE_B-1:0]           side_s1;
	logic [UNIT_W-1:0]           azx_mag, azy_mag;
	logic [2:0][VEC_W-1:0]       az_ext;

	always_comb begin
		for (int i = 0; i < 3; i++) az_ext[i] = VEC_W'($signed(az_a[i]));
		azx_mag = az_a[0][UNIT_W-1] ? (UNIT_W'(0) - az_a[0]) : az_a[0];
		azy_mag = az_a[1][UNIT_W-1] ? (UNIT_W'(0) - az_a[1]) : az_a[1];
	end

	always_ff @(posedge clk) begin
		if ((azx_mag < EPS_Q30) && (azy_mag < EPS_Q30)) begin
			tx_s1 <= {VEC_W'(0) - az_ext[0], VEC_W'(0), az_ext[2]};
		end else begin
			tx_s1 <= {VEC_W'(0), az_ext[0], VEC_W'(0) - az_ext[1]};
		end
		side_s1 <= {case_a, p_a, az_a};
	end

	// ---- normaliser B: ax
	logic                    vb;
	logic [2:0][UNIT_W-1:0]  ax_b;
	logic [SIDE_B-1:0]       side_b;

	aaocs_unit #(.SIDE_W(SIDE_B)) u_norm_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_vec   (tx_s1),
		.in_side  (side_s1),
		.out_valid(vb),
		.out_vec  (ax_b),
		.out_side (side_b)
	);

	// ---- s2/s3: ty = az x ax, products then differences
	logic                        valid_s2, valid_s3;
	logic signed [VEC_W-1:0]     cp_s2 [6];
	logic [SIDE_C-1:0]           side_s2, side_s3;
	logic [2:0][VEC_W-1:0]       ty_s3;
	logic [2:0][UNIT_W-1:0]      az_b;

	assign az_b = side_b[3*UNIT_W-1:0];

	always_ff @(posedge clk) begin
		cp_s2[0] <= $signed(az_b[1]) * $signed(ax_b[2]);
		cp_s2[1] <= $signed(az_b[2]) * $signed(ax_b[1]);
		cp_s2[2] <= $signed(az_b[2]) * $signed(ax_b[0]);
		cp_s2[3] <= $signed(az_b[0]) * $signed(ax_b[2]);
		cp_s2[4] <= $signed(az_b[0]) * $signed(ax_b[1]);
		cp_s2[5] <= $signed(az_b[1]) * $signed(ax_b[0]);
		side_s2  <= {side_b, ax_b};
		ty_s3    <= {cp_s2[4] - cp_s2[5], cp_s2[2] - cp_s2[3], cp_s2[0] - cp_s2[1]};
		side_s3  <= side_s2;
	end

	// ---- normaliser C: ay
	logic                    vc;
	logic [2:0][UNIT_W-1:0]  ay_c, az_c, ax_c;
	ext_case_t               case_c;
	logic [2:0][COORD_W-1:0] p_c;

	aaocs_unit #(.SIDE_W(SIDE_C)) u_norm_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_vec   (ty_s3),
		.in_side  (side_s3),
		.out_valid(vc),
		.out_vec  (ay_c),
		.out_side ({case_c, p_c, az_c, ax_c})
	);

	// ---- s4..s6: dot products, rounding, saturation, special cases
	logic                          valid_s4, valid_s5;
	logic signed [VEC_W-1:0]       dp_s4 [3][3];
	ext_case_t                     case_s4, case_s5;
	logic [2:0][COORD_W-1:0]       p_s4, p_s5;
	logic signed [SUM_W-1:0]       sum_s5 [3];
	logic [2:0][UNIT_W-1:0]        axes_c [3];
	logic signed [SUM_W-1:0]       rsh_c [3];
	logic [2:0][COORD_W-1:0]       res_c;
	logic [2:0]                    clip_c;

	assign axes_c[0] = ax_c;
	assign axes_c[1] = ay_c;
	assign axes_c[2] = az_c;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				dp_s4[j][i] <= $signed(p_c[i]) * $signed(axes_c[j][i]);
			end
			// half-up rounding bias for the Q2.30 -> Q16.16 step
			sum_s5[j] <= SUM_W'(dp_s4[j][0]) + SUM_W'(dp_s4[j][1])
				+ SUM_W'(dp_s4[j][2]) + SUM_W'(64'sd536870912);
		end
		case_s4 <= case_c;
		p_s4    <= p_c;
		case_s5 <= case_s4;
		p_s5    <= p_s4;
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rsh_c[j] = sum_s5[j] >>> 30;
			// clip when the bits above the sign of a 32-bit word disagree
			clip_c[j] = !((rsh_c[j][SUM_W-1:COORD_W-1] == '0)
				|| (rsh_c[j][SUM_W-1:COORD_W-1] == '1));
			if (clip_c[j]) res_c[j] = rsh_c[j][SUM_W-1] ? COORD_MIN : COORD_MAX;
			else           res_c[j] = rsh_c[j][COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		zero_extrusion <= 1'b0;
		if (case_s5.up) begin
			{ocs_z, ocs_y, ocs_x} <= p_s5;
			saturated <= 1'b0;
		end else if (case_s5.down) begin
			ocs_x     <= ($signed(p_s5[0]) == COORD_MIN) ? COORD_MAX
				: (COORD_W'(0) - p_s5[0]);
			ocs_y     <= p_s5[1];
			ocs_z     <= p_s5[2];
			saturated <= ($signed(p_s5[0]) == COORD_MIN);
		end else if (case_s5.zero) begin
			ocs_x          <= '0;
			ocs_y          <= '0;
			ocs_z          <= '0;
			saturated      <= 1'b0;
			zero_extrusion <= 1'b1;
		end else begin
			ocs_x     <= res_c[0];
			ocs_y     <= res_c[1];
			ocs_z     <= res_c[2];
			saturated <= |clip_c;
		end
	end

	// ---- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s0 <= start;
			valid_s1 <= va;
			valid_s2 <= vb;
			valid_s3 <= valid_s2;
			valid_s4 <= vc;
			valid_s5 <= valid_s4;
			done     <= valid_s5;
		end
	end

	assign busy = 1'b0;

	// ---- checks
	`AAOCS_ASSERT_IMPLY(a_latency, done, $past(start, CORE_LAT), "done without a start beat")
	`AAOCS_ASSERT_IMPLY(a_zero_out, done && zero_extrusion,
		(ocs_x == '0) && (ocs_y == '0) && (ocs_z == '0), "zero extrusion gave nonzero")
	`AAOCS_ASSERT_NEVER(a_zero_sat, done && zero_extrusion && saturated,
		"zero extrusion flagged saturated")
	`AAOCS_ASSERT_IMPLY(a_sat_rail, done && saturated,
		(ocs_x == COORD_MAX) || (ocs_x == COORD_MIN) || (ocs_y == COORD_MAX) ||
		(ocs_y == COORD_MIN) || (ocs_z == COORD_MAX) || (ocs_z == COORD_MIN),
		"saturated with no coordinate on a rail")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for arbitrary_axis_ocs_transform_core: it drives points and extrusions,
// works out each expected OCS result in the bench itself, and compares every done beat.
// Depends on aaocs_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
	import aaocs_pkg::*;

	// one input beat
	typedef struct packed {
		logic signed [COORD_W-1:0] px, py, pz, ex, ey, ez;
	} vertex_t;

	// one result beat
	typedef struct packed {
		logic signed [COORD_W-1:0] ox, oy, oz;
		logic sat, zero;
	} ocs_t;

	typedef struct packed {
		longint x, y, z;
	} vec3_t;

	localparam int WATCHDOG_LIMIT = 5000;    // core latency plus worst sender gap, with margin
	localparam int DRAIN_CYCLES   = CORE_LAT + 100;
	localparam int RANDOM_BEATS   = 530;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] point_x, point_y, point_z;
	logic signed [COORD_W-1:0] extr_x, extr_y, extr_z;
	logic done;
	logic signed [COORD_W-1:0] ocs_x, ocs_y, ocs_z;
	logic saturated, zero_extrusion;

	vertex_t vertex_queue[$];   // beats still to send
	ocs_t    ocs_expected[$];   // predictions waiting for a done beat
	vertex_t vertex_on_bus;
	int      sent_count = 0;
	int      error_count = 0;
	int      quiet_cycles = 0;
	int      idle_pct;

	always #5 clk = ~clk;

	arbitrary_axis_ocs_transform_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.extr_x(extr_x), .extr_y(extr_y), .extr_z(extr_z),
		.done(done), .ocs_x(ocs_x), .ocs_y(ocs_y), .ocs_z(ocs_z),
		.saturated(saturated), .zero_extrusion(zero_extrusion)
	);

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	// bit-by-bit integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n    = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// scale magnitudes so the largest sits in [2^30, 2^31), then divide by the length;
	// result is Q2.30 with round-half-up and the sign put back
	function automatic vec3_t to_unit(vec3_t v);
		longint unsigned m[3];
		longint unsigned mx, sumsq, len, q;
		longint          comp[3];
		vec3_t           u;
		comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
		for (int i = 0; i < 3; i++) m[i] = abs64(comp[i]);
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) return '0;
		while (mx >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++) m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] <<= 1;
			mx <<= 1;
		end
		sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (len >> 1)) / len;
			comp[i] = comp[i] < 0 ? -longint'(q) : longint'(q);
		end
		u.x = comp[0]; u.y = comp[1]; u.z = comp[2];
		return u;
	endfunction

	// Q16.16 x Q2.30 summed exactly, rounded back to Q16.16 (floor after adding half)
	function automatic longint dot_to_q16(vec3_t p, vec3_t a);
		longint s;
		s = p.x * a.x + p.y * a.y + p.z * a.z + (longint'(1) << 29);
		return s >>> 30;
	endfunction

	function automatic logic signed [COORD_W-1:0] clip32(longint v, inout logic flag);
		if (v > longint'(COORD_MAX)) begin
			flag = 1'b1;
			return COORD_MAX;
		end
		if (v < longint'(COORD_MIN)) begin
			flag = 1'b1;
			return COORD_MIN;
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic ocs_t predict_ocs(vertex_t t);
		ocs_t  r;
		vec3_t p, e, az, tx, ax, ty, ay;
		logic  sat;
		r   = '0;
		sat = 1'b0;
		p.x = t.px; p.y = t.py; p.z = t.pz;
		e.x = t.ex; e.y = t.ey; e.z = t.ez;
		if (t.ex == 0 && t.ey == 0 && t.ez == ONE_Q16) begin
			// straight up: pass through
			r.ox = t.px; r.oy = t.py; r.oz = t.pz;
			return r;
		end
		if (t.ex == 0 && t.ey == 0 && t.ez == -ONE_Q16) begin
			// straight down: mirror x only
			r.ox = clip32(-p.x, sat);
			r.oy = t.py; r.oz = t.pz;
			r.sat = sat;
			return r;
		end
		if (t.ex == 0 && t.ey == 0 && t.ez == 0) begin
			r.zero = 1'b1;
			return r;
		end
		az = to_unit(e);
		if (abs64(az.x) < EPS_Q30 && abs64(az.y) < EPS_Q30) begin
			tx.x = az.z; tx.y = 0; tx.z = -az.x;     // world Y cross az
		end else begin
			tx.x = -az.y; tx.y = az.x; tx.z = 0;     // world Z cross az
		end
		ax = to_unit(tx);
		ty.x = az.y * ax.z - az.z * ax.y;
		ty.y = az.z * ax.x - az.x * ax.z;
		ty.z = az.x * ax.y - az.y * ax.x;
		ay = to_unit(ty);
		r.ox  = clip32(dot_to_q16(p, ax), sat);
		r.oy  = clip32(dot_to_q16(p, ay), sat);
		r.oz  = clip32(dot_to_q16(p, az), sat);
		r.sat = sat;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic signed [COORD_W-1:0] rnd_coord();
		case ($urandom_range(0, 5))
			0:       return COORD_MAX;
			1:       return COORD_MIN;
			2:       return $urandom_range(0, 4) - 2;
			3:       return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vertex_t rnd_vertex();
		vertex_t t;
		t.px = rnd_coord(); t.py = rnd_coord(); t.pz = rnd_coord();
		case ($urandom_range(0, 19))
			0: begin t.ex = 0; t.ey = 0; t.ez = ONE_Q16; end
			1: begin t.ex = 0; t.ey = 0; t.ez = -ONE_Q16; end
			2: begin t.ex = 0; t.ey = 0; t.ez = 0; end
			3, 4, 5, 6: begin
				// close to the world z axis, either side of the 1/64 switch
				t.ez = $urandom_range(0, 1) ? $signed($urandom) : ONE_Q16;
				if (t.ez == 0) t.ez = 1;
				t.ex = $signed($urandom_range(0, 4000)) - 2000;
				t.ey = $signed($urandom_range(0, 4000)) - 2000;
			end
			7, 8: begin
				t.ex = $signed($urandom_range(0, 6)) - 3;
				t.ey = $signed($urandom_range(0, 6)) - 3;
				t.ez = $signed($urandom_range(0, 6)) - 3;
			end
			default: begin
				t.ex = rnd_coord(); t.ey = rnd_coord(); t.ez = rnd_coord();
			end
		endcase
		return t;
	endfunction

	function automatic vertex_t mk(int px, int py, int pz, int ex, int ey, int ez);
		vertex_t t;
		t.px = px; t.py = py; t.pz = pz; t.ex = ex; t.ey = ey; t.ez = ez;
		return t;
	endfunction

	// append a beat to the send queue
	task automatic add_vertex(vertex_t v);
		vertex_queue = {vertex_queue, v};
	endtask

	// ---------------------------------------------------------------- reporting

	task automatic report_mismatch(string what, longint got, longint want);
		$display("tb_top: %0t %s mismatch: got %0d want %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------- driver

	// idle pattern tracks progress: none, sender gaps, none, lighter gaps, sender gaps again
	always_comb begin
		case (sent_count / 110)
			0:       idle_pct = 0;
			1:       idle_pct = 46;
			2:       idle_pct = 0;
			3:       idle_pct = 30;
			default: idle_pct = 46;
		endcase
	end

	always @(posedge clk or negedge arst_n) begin
		vertex_t nxt;
		logic    take;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			take = start && !busy;
			if (take) begin
				ocs_expected = {ocs_expected, predict_ocs(vertex_on_bus)};
				sent_count <= sent_count + 1;
			end
			if (take || !start) begin
				// slot free: load the next beat unless this cycle idles
				if (vertex_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					nxt = vertex_queue.pop_front();
					vertex_on_bus <= nxt;
					point_x <= nxt.px; point_y <= nxt.py; point_z <= nxt.pz;
					extr_x  <= nxt.ex; extr_y  <= nxt.ey; extr_z  <= nxt.ez;
					start   <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		ocs_t want;
		if (arst_n && done) begin
			if (ocs_expected.size() == 0) begin
				$display("tb_top: %0t unexpected done beat", $realtime);
				error_count++;
			end else begin
				want = ocs_expected.pop_front();
				if (ocs_x !== want.ox) report_mismatch("ocs_x", ocs_x, want.ox);
				if (ocs_y !== want.oy) report_mismatch("ocs_y", ocs_y, want.oy);
				if (ocs_z !== want.oz) report_mismatch("ocs_z", ocs_z, want.oz);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
				if (zero_extrusion !== want.zero)
					report_mismatch("zero_extrusion", zero_extrusion, want.zero);
			end
		end
	end

	// watchdog: cycles with neither an accepted input nor a done beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: watchdog expired");
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;

		// directed beats: the three shortcut extrusions, range edges, axis switch
		add_vertex(mk(32'h0001_2345, -7, 32'h7fff_ffff, 0, 0, 32'h0001_0000));
		add_vertex(mk(32'h8000_0000, 32'h8000_0000, 3, 0, 0, 32'h0001_0000));
		add_vertex(mk(32'h1234_5678, -99, 5, 0, 0, -32'h0001_0000));
		add_vertex(mk(32'h8000_0000, 1, 2, 0, 0, -32'h0001_0000));   // negating min x
		add_vertex(mk(32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 0, -32'h0001_0000));
		add_vertex(mk(32'h7fff_ffff, 32'h8000_0000, 9, 0, 0, 0));      // zero extrusion
		add_vertex(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 32'h0002_0000));
		add_vertex(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, -32'h0003_0000));
		add_vertex(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0, 0));
		add_vertex(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 32'h0001_0000, 0));
		add_vertex(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1));   // clips
		add_vertex(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1));
		add_vertex(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		add_vertex(mk(32'h0010_0000, -32'h0020_0000, 32'h0030_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		// either side of the 1/64 threshold
		add_vertex(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			1023, 0, 32'h0001_0000));
		add_vertex(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			1024, 0, 32'h0001_0000));
		add_vertex(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			0, -1030, -32'h0001_0000));
		add_vertex(mk(-5, 7, -11, 0, 0, 1));            // tiny extrusions
		add_vertex(mk(-5, 7, -11, -1, 0, 0));
		add_vertex(mk(-5, 7, -11, 0, 0, -1));
		add_vertex(mk(32'h0000_ffff, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
		add_vertex(mk(0, 0, 0, 32'h1234, 32'h5678, 32'h9abc));
		for (int i = 0; i < RANDOM_BEATS; i++) add_vertex(rnd_vertex());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (vertex_queue.size() == 0);
		@(posedge clk);
		while (start || ocs_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
